FILE: rtl/ght_pkg.sv
// Shared types and constants for the generational handle table.
// No dependencies; used by the top level through scoped names.
`default_nettype none

package ght_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [2:0] {
      ACT_CREATE  = 3'd0,
      ACT_DESTROY = 3'd1,
      ACT_ALLOC   = 3'd2,
      ACT_DEREF   = 3'd3,
      ACT_FREE    = 3'd4
   } action_type;

   // Result codes carried on rsp_tuser
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ARENA = 3'd1,
      ST_BAD_SIZE  = 3'd2,
      ST_STALE     = 3'd3,
      ST_FULL      = 3'd4,
      ST_EXHAUSTED = 3'd5
   } status_type;

   localparam logic [31:0] GEN_SATURATED = 32'hFFFF_FFFF;
   localparam logic [31:0] GEN_FIRST     = 32'd1;
   localparam int          FIELD_BITS    = 16;
   localparam int          PORT_ADDR_BITS = 48;

endpackage

`default_nettype wire

FILE: rtl/ght_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/generational_handle_table.sv
// Generational handle table: per-arena slot tables with free stacks.
// Depends on ght_pkg and ght_ram.
//
// One request is in work at a time; req_tready is high only while the block is idle and no
// response is waiting. A create, destroy, bad request or unknown kind is answered at decode; a
// deref or free goes on to a slot read and a compare (decode, slot read, compare); an alloc
// pops free-stack entries one by one (stack read, then slot read, then generation check),
// dropping saturated ones, and ends on the first unsaturated one, or on a fresh slot or a full
// table when the stack is empty. The stack and slot memory reads are chained. Memories need no
// clearing after reset.
`default_nettype none

module generational_handle_table #(
   parameter int ARENA_IDS       = 16,
   parameter int SLOTS_PER_ARENA = 256,
   parameter int ADDRESS_BITS    = 48
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [15:0] arena_number, [47:16] alloc_size, [95:48] buffer_address, [159:96] handle_in
   input  wire logic [159:0] req_tdata,
   // [2:0] action
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [63:0] handle_out, [79:64] arena_out, [127:80] address_out
   output logic      [127:0] rsp_tdata,
   // [2:0] status, [3] release_buffer
   output logic      [3:0]   rsp_tuser
);

   localparam int TW  = $clog2(ARENA_IDS * SLOTS_PER_ARENA);
   localparam int SW  = (SLOTS_PER_ARENA > 1) ? $clog2(SLOTS_PER_ARENA) : 1;
   localparam int CW  = $clog2(SLOTS_PER_ARENA + 1);
   localparam int IW  = $clog2(ARENA_IDS);
   localparam int NW  = $clog2(ARENA_IDS + 1);
   localparam int ASW = (ADDRESS_BITS < ght_pkg::PORT_ADDR_BITS) ?
                        ADDRESS_BITS : ght_pkg::PORT_ADDR_BITS;
   localparam int RW  = 1 + 32 + ASW;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_POP, S_POPS, S_POPG, S_FRESH, S_RD, S_CMP
   } state_type;

   state_type           state_ff, state_in;
   ght_pkg::action_type act_ff, act_in;
   logic [15:0]         arena_ff, arena_in;
   logic                neg_ff, neg_in;
   logic [ASW-1:0]      buf_ff, buf_in;
   logic [63:0]         hdl_ff, hdl_in;
   logic [TW-1:0]       base_ff, base_in;
   logic [TW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       sl_ff, sl_in;
   logic [IW-1:0]       ai_ff, ai_in;
   logic [NW-1:0]       next_ff, next_in;

   logic                rv_ff, rv_in;
   ght_pkg::status_type st_ff, st_in;
   logic [63:0]         ho_ff, ho_in;
   logic [15:0]         ao_ff, ao_in;
   logic [47:0]         ad_ff, ad_in;
   logic                rel_ff, rel_in;

   logic [CW-1:0]       fd_ff [ARENA_IDS];
   logic [CW-1:0]       su_ff [ARENA_IDS];
   logic                alive_ff [ARENA_IDS];

   // Per-arena write controls
   logic [IW-1:0]       pa_idx;
   logic                alive_we, alive_wv, fd_we, su_we;
   logic [CW-1:0]       fd_wv, su_wv;

   // Memory ports
   logic                slot_we, stk_we;
   logic [TW-1:0]       slot_waddr, slot_raddr, stk_waddr, stk_raddr;
   logic [RW-1:0]       slot_wdata, slot_rdata;
   logic [SW-1:0]       stk_wdata, stk_rdata;

   logic [15:0]         sel_ar;
   logic                ar_ok;
   logic [CW-1:0]       fd_cur, su_cur;
   logic [31:0]         rd_gen;
   logic                rd_use;
   logic [ASW-1:0]      rd_addr;

   ght_ram #(.WIDTH(RW), .DEPTH(ARENA_IDS * SLOTS_PER_ARENA)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   ght_ram #(.WIDTH(SW), .DEPTH(ARENA_IDS * SLOTS_PER_ARENA)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {ad_ff, ao_ff, ho_ff};
   assign rsp_tuser  = {rel_ff, st_ff};

   // Arena looked up at decode, and the entry read from the slot memory
   assign sel_ar  = (act_ff == ght_pkg::ACT_DEREF || act_ff == ght_pkg::ACT_FREE) ?
                    hdl_ff[31:16] : arena_ff;
   assign ar_ok   = (sel_ar != 16'd0) && ({1'b0, sel_ar} < 17'(ARENA_IDS)) &&
                    alive_ff[sel_ar[IW-1:0]];
   assign fd_cur  = fd_ff[ai_ff];
   assign su_cur  = su_ff[ai_ff];
   assign rd_use  = slot_rdata[RW-1];
   assign rd_gen  = slot_rdata[RW-2 -: 32];
   assign rd_addr = slot_rdata[ASW-1:0];

   // Sequencer: decode, walk the free stack, read-check-update the slot entry
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      arena_in = arena_ff;
      neg_in   = neg_ff;
      buf_in   = buf_ff;
      hdl_in   = hdl_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      sl_in    = sl_ff;
      ai_in    = ai_ff;
      next_in  = next_ff;
      rv_in    = rv_ff;
      st_in    = st_ff;
      ho_in    = ho_ff;
      ao_in    = ao_ff;
      ad_in    = ad_ff;
      rel_in   = rel_ff;

      pa_idx   = ai_ff;
      alive_we = 1'b0;
      alive_wv = 1'b0;
      fd_we    = 1'b0;
      fd_wv    = fd_cur;
      su_we    = 1'b0;
      su_wv    = su_cur;

      slot_we    = 1'b0;
      slot_waddr = idx_ff;
      slot_wdata = {1'b1, ght_pkg::GEN_FIRST, buf_ff};
      slot_raddr = base_ff + TW'(sl_ff);
      stk_we     = 1'b0;
      stk_waddr  = base_ff + TW'(fd_cur);
      stk_wdata  = sl_ff;
      stk_raddr  = base_ff + TW'(fd_cur - 1'b1);

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               act_in   = ght_pkg::action_type'(req_tuser);
               arena_in = req_tdata[15:0];
               neg_in   = req_tdata[47];
               buf_in   = req_tdata[48 +: ASW];
               hdl_in   = req_tdata[159:96];
               st_in    = ght_pkg::ST_OK;
               ho_in    = 64'd0;
               ao_in    = 16'd0;
               ad_in    = 48'd0;
               rel_in   = 1'b0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            ai_in    = sel_ar[IW-1:0];
            base_in  = TW'(sel_ar[IW-1:0]) * TW'(SLOTS_PER_ARENA);
            sl_in    = hdl_ff[SW-1:0];
            state_in = S_IDLE;
            rv_in    = 1'b1;
            unique case (act_ff)
               ght_pkg::ACT_CREATE: begin
                  if (next_ff >= NW'(ARENA_IDS)) begin
                     st_in = ght_pkg::ST_EXHAUSTED;
                  end else begin
                     ao_in    = 16'(next_ff);
                     pa_idx   = next_ff[IW-1:0];
                     alive_we = 1'b1;
                     alive_wv = 1'b1;
                     fd_we    = 1'b1;
                     fd_wv    = '0;
                     su_we    = 1'b1;
                     su_wv    = '0;
                     next_in  = next_ff + 1'b1;
                  end
               end
               ght_pkg::ACT_DESTROY: begin
                  // Ids are never reused, so the slot marks need no clearing
                  if (!ar_ok) begin
                     st_in = ght_pkg::ST_BAD_ARENA;
                  end else begin
                     pa_idx   = sel_ar[IW-1:0];
                     alive_we = 1'b1;
                     alive_wv = 1'b0;
                  end
               end
               ght_pkg::ACT_ALLOC: begin
                  if (neg_ff || !ar_ok) begin
                     st_in  = neg_ff ? ght_pkg::ST_BAD_SIZE : ght_pkg::ST_BAD_ARENA;
                     ad_in  = 48'(buf_ff);
                     rel_in = 1'b1;
                  end else begin
                     rv_in    = 1'b0;
                     state_in = S_POP;
                  end
               end
               ght_pkg::ACT_DEREF, ght_pkg::ACT_FREE: begin
                  if (hdl_ff == 64'd0) begin
                     st_in = ght_pkg::ST_STALE;
                  end else if (!ar_ok) begin
                     st_in = ght_pkg::ST_BAD_ARENA;
                  end else if ({1'b0, hdl_ff[15:0]} >=
                               17'(su_ff[sel_ar[IW-1:0]])) begin
                     st_in = ght_pkg::ST_STALE;
                  end else begin
                     rv_in    = 1'b0;
                     state_in = S_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP: begin
            // Pop one entry, or fall back to a fresh slot
            if (fd_cur == '0) begin
               state_in = S_FRESH;
            end else begin
               fd_we    = 1'b1;
               fd_wv    = fd_cur - 1'b1;
               state_in = S_POPS;
            end
         end
         S_POPS: begin
            sl_in      = stk_rdata;
            slot_raddr = base_ff + TW'(stk_rdata);
            idx_in     = base_ff + TW'(stk_rdata);
            state_in   = S_POPG;
         end
         S_POPG: begin
            // Drop entries whose generation has saturated
            if (rd_gen != ght_pkg::GEN_SATURATED) begin
               slot_we    = 1'b1;
               slot_wdata = {1'b1, rd_gen, buf_ff};
               ho_in      = {rd_gen, arena_ff, 16'(sl_ff)};
               rv_in      = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_POP;
            end
         end
         S_FRESH: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
            if (su_cur >= CW'(SLOTS_PER_ARENA)) begin
               st_in  = ght_pkg::ST_FULL;
               ad_in  = 48'(buf_ff);
               rel_in = 1'b1;
            end else begin
               su_we      = 1'b1;
               su_wv      = su_cur + 1'b1;
               slot_we    = 1'b1;
               slot_waddr = base_ff + TW'(su_cur);
               ho_in      = {ght_pkg::GEN_FIRST, arena_ff, 16'(su_cur)};
            end
         end
         S_RD: begin
            idx_in   = base_ff + TW'(sl_ff);
            state_in = S_CMP;
         end
         S_CMP: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
            if (!rd_use || rd_gen != hdl_ff[63:32]) begin
               st_in = ght_pkg::ST_STALE;
            end else begin
               ad_in = 48'(rd_addr);
               if (act_ff == ght_pkg::ACT_FREE) begin
                  rel_in     = 1'b1;
                  slot_we    = 1'b1;
                  slot_wdata = {1'b0,
                                (rd_gen == ght_pkg::GEN_SATURATED) ? rd_gen :
                                rd_gen + 32'd1, rd_addr};
                  if (rd_gen != ght_pkg::GEN_SATURATED &&
                      fd_cur < CW'(SLOTS_PER_ARENA)) begin
                     stk_we = 1'b1;
                     fd_we  = 1'b1;
                     fd_wv  = fd_cur + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, per-arena counters and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         next_ff  <= NW'(1);
         rv_ff    <= 1'b0;
         for (int i = 0; i < ARENA_IDS; i++) begin
            alive_ff[i] <= 1'b0;
            fd_ff[i]    <= '0;
            su_ff[i]    <= '0;
         end
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         rv_ff    <= rv_in;
         if (alive_we) begin
            alive_ff[pa_idx] <= alive_wv;
         end
         if (fd_we) begin
            fd_ff[pa_idx] <= fd_wv;
         end
         if (su_we) begin
            su_ff[pa_idx] <= su_wv;
         end
      end
      act_ff   <= act_in;
      arena_ff <= arena_in;
      neg_ff   <= neg_in;
      buf_ff   <= buf_in;
      hdl_ff   <= hdl_in;
      base_ff  <= base_in;
      idx_ff   <= idx_in;
      sl_ff    <= sl_in;
      ai_ff    <= ai_in;
      st_ff    <= st_in;
      ho_ff    <= ho_in;
      ao_ff    <= ao_in;
      ad_ff    <= ad_in;
      rel_ff   <= rel_in;
   end

   // A new request is taken only with no response pending
   a_ready_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("ready while a response is pending");

   // A failed request never hands out a handle
   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != ght_pkg::ST_OK |-> rsp_tdata[63:0] == 64'd0)
      else $error("handle on failed request");

   // Arena id counter never passes the id space
   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= NW'(ARENA_IDS))
      else $error("arena counter overflow");

   // Accepting a request starts the sequencer
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_DECODE)
      else $error("accepted request not decoded");

endmodule

`default_nettype wire
